// ===== hdl/cduleb_pkg.sv =====
// Package for the class data ULEB128 decoder.
// Holds the decode phase type, the value queue entry type and the kind codes.
// No dependencies.
`timescale 1ns / 1ps

package cduleb_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COUNTS = 3'd1,
        PH_SEC0   = 3'd2,
        PH_SEC1   = 3'd3,
        PH_SEC2   = 3'd4,
        PH_SEC3   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [31:0] value;
        logic        first;
    } t_val;

    localparam logic [2:0] KIND_EMPTY    = 3'd4;
    localparam logic [2:0] LEB_LAST_BYTE = 3'd4;
    localparam logic [1:0] SLOT_DELTA    = 2'd0;
    localparam logic [1:0] SLOT_FLAGS    = 2'd1;
    localparam logic [1:0] SLOT_CODE     = 2'd2;
    localparam logic [1:0] SLOT_LAST_CNT = 2'd3;
    localparam int         QUEUE_DEPTH   = 2;

endpackage

// ===== hdl/cduleb_front.sv =====
// Front part: accepts bytes and assembles ULEB128 values.
// Pushes each finished value, tagged when it opens an item, into the queue.
// Depends on cduleb_pkg.
`timescale 1ns / 1ps

module cduleb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_item,
    input  logic              i_q_full,
    output logic              o_push,
    output cduleb_pkg::t_val  o_push_val
);

    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_first, n_first;

    logic        accept;
    logic [31:0] acc_base;
    logic [2:0]  cnt_base;
    logic        first_base;
    logic [5:0]  shamt;
    logic [31:0] merged;
    logic        done;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        acc_base   = i_start_of_item ? 32'd0 : r_acc;
        cnt_base   = i_start_of_item ? 3'd0 : r_cnt;
        first_base = i_start_of_item ? 1'b1 : r_first;
        shamt      = {cnt_base, 3'b000} - {3'b000, cnt_base};
        merged     = acc_base | ({25'd0, i_data_byte[6:0]} << shamt);
        done       = !i_data_byte[7] || (cnt_base == cduleb_pkg::LEB_LAST_BYTE);
    end

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_first = r_first;
        if (accept) begin
            if (done) begin
                n_acc   = 32'd0;
                n_cnt   = 3'd0;
                n_first = 1'b0;
            end else begin
                n_acc   = merged;
                n_cnt   = cnt_base + 3'd1;
                n_first = first_base;
            end
        end
    end

    assign o_push           = accept && done;
    assign o_push_val.value = merged;
    assign o_push_val.first = first_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 32'd0;
            r_cnt   <= 3'd0;
            r_first <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

endmodule

// ===== hdl/cduleb_queue.sv =====
// Two-entry queue of decoded values between front and back parts.
// Depends on cduleb_pkg.
`timescale 1ns / 1ps

module cduleb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cduleb_pkg::t_val  i_push_val,
    output logic              o_full,
    output logic              o_q_valid,
    output cduleb_pkg::t_val  o_q_val,
    input  logic              i_pop
);

    cduleb_pkg::t_val r_mem [cduleb_pkg::QUEUE_DEPTH];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full    = (r_count == 2'(cduleb_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_val   = r_mem[r_rptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== hdl/cduleb_back.sv =====
// Back part: walks counts and records from the queued values, emits records.
// Holds the section state machine and the output register.
// Depends on cduleb_pkg.
`timescale 1ns / 1ps

module cduleb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  cduleb_pkg::t_val  i_q_val,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_entry_kind,
    output logic [31:0]       o_member_index,
    output logic [31:0]       o_member_flags,
    output logic [31:0]       o_code_offset,
    output logic              o_last_of_item
);

    cduleb_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_slot, n_slot;
    logic [31:0] r_counts [4];
    logic [31:0] r_left, n_left;
    logic [31:0] r_index, n_index;
    logic [31:0] r_held, n_held;

    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [31:0] r_out_index, r_out_flags, r_out_code;
    logic        r_out_last;

    logic [31:0] v;
    logic        first;
    logic        is_sec, is_method;
    logic [2:0]  kind;
    logic [3:0]  nz;
    logic [2:0]  from;
    logic        found;
    logic [1:0]  found_sec;
    logic        enter;
    logic        emit;
    logic        cnt_wr;
    logic [1:0]  cnt_idx;
    logic [2:0]  e_kind;
    logic [31:0] e_flags, e_code;
    logic        e_last;

    assign v         = i_q_val.value;
    assign first     = i_q_val.first;
    assign o_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign is_sec    = (r_phase != cduleb_pkg::PH_IDLE) && (r_phase != cduleb_pkg::PH_COUNTS);
    assign is_method = (r_phase == cduleb_pkg::PH_SEC2) || (r_phase == cduleb_pkg::PH_SEC3);
    assign kind      = r_phase - 3'd2;

    // Search for the next section with entries.
    always_comb begin
        nz[0] = (r_counts[0] != 32'd0);
        nz[1] = (r_counts[1] != 32'd0);
        nz[2] = (r_counts[2] != 32'd0);
        nz[3] = (r_counts[3] != 32'd0);
        if (!first && r_phase == cduleb_pkg::PH_COUNTS) begin
            nz[3] = (v != 32'd0);
            from  = 3'd0;
        end else begin
            from  = kind + 3'd1;
        end
        found     = 1'b0;
        found_sec = 2'd0;
        for (int s = 3; s >= 0; s--) begin
            if (nz[s] && (3'(s) >= from)) begin
                found     = 1'b1;
                found_sec = 2'(s);
            end
        end
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        enter   = 1'b0;
        if (o_pop) begin
            if (first) begin
                n_phase = cduleb_pkg::PH_COUNTS;
            end else begin
                unique case (r_phase)
                    cduleb_pkg::PH_IDLE: begin
                        n_phase = cduleb_pkg::PH_IDLE;
                    end
                    cduleb_pkg::PH_COUNTS: begin
                        if (r_slot == cduleb_pkg::SLOT_LAST_CNT) begin
                            enter = 1'b1;
                        end
                    end
                    cduleb_pkg::PH_SEC0, cduleb_pkg::PH_SEC1,
                    cduleb_pkg::PH_SEC2, cduleb_pkg::PH_SEC3: begin
                        if (r_slot != cduleb_pkg::SLOT_DELTA
                            && !(r_slot == cduleb_pkg::SLOT_FLAGS && is_method)
                            && r_left == 32'd1) begin
                            enter = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = cduleb_pkg::PH_IDLE;
                    end
                endcase
            end
            if (enter) begin
                n_phase = found ? cduleb_pkg::t_phase'({1'b0, found_sec} + 3'd2)
                                : cduleb_pkg::PH_IDLE;
            end
        end
    end

    // Datapath and results.
    always_comb begin
        n_slot  = r_slot;
        n_left  = r_left;
        n_index = r_index;
        n_held  = r_held;
        emit    = 1'b0;
        cnt_wr  = 1'b0;
        cnt_idx = r_slot;
        e_kind  = kind;
        e_flags = r_held;
        e_code  = v;
        e_last  = 1'b0;
        if (o_pop) begin
            if (first) begin
                cnt_wr  = 1'b1;
                cnt_idx = 2'd0;
                n_slot  = 2'd1;
            end else if (r_phase == cduleb_pkg::PH_COUNTS) begin
                cnt_wr = 1'b1;
                n_slot = r_slot + 2'd1;
                if (enter && !found) begin
                    emit   = 1'b1;
                    e_kind = cduleb_pkg::KIND_EMPTY;
                    e_flags = 32'd0;
                    e_code  = 32'd0;
                    e_last  = 1'b1;
                end
            end else if (is_sec) begin
                if (r_slot == cduleb_pkg::SLOT_DELTA) begin
                    n_index = r_index + v;
                    n_slot  = cduleb_pkg::SLOT_FLAGS;
                end else if (r_slot == cduleb_pkg::SLOT_FLAGS && is_method) begin
                    n_held = v;
                    n_slot = cduleb_pkg::SLOT_CODE;
                end else begin
                    emit   = 1'b1;
                    n_slot = cduleb_pkg::SLOT_DELTA;
                    n_left = r_left - 32'd1;
                    if (r_slot == cduleb_pkg::SLOT_FLAGS) begin
                        n_held  = v;
                        e_flags = v;
                        e_code  = 32'd0;
                    end
                    e_last = enter && !found;
                end
            end
            if (enter) begin
                n_slot  = cduleb_pkg::SLOT_DELTA;
                n_index = 32'd0;
                n_left  = found ? r_counts[found_sec] : 32'd0;
                if (found && found_sec == 2'd3 && r_phase == cduleb_pkg::PH_COUNTS) begin
                    n_left = v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_wr) begin
            r_counts[cnt_idx] <= v;
        end
        if (emit) begin
            r_out_kind  <= e_kind;
            r_out_index <= (e_kind == cduleb_pkg::KIND_EMPTY) ? 32'd0 : r_index;
            r_out_flags <= e_flags;
            r_out_code  <= e_code;
            r_out_last  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cduleb_pkg::PH_IDLE;
            r_slot      <= 2'd0;
            r_left      <= 32'd0;
            r_index     <= 32'd0;
            r_held      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_left  <= n_left;
            r_index <= n_index;
            r_held  <= n_held;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_kind   = r_out_kind;
    assign o_member_index = r_out_index;
    assign o_member_flags = r_out_flags;
    assign o_code_offset  = r_out_code;
    assign o_last_of_item = r_out_last;

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == cduleb_pkg::KIND_EMPTY)
        |-> (r_out_last && r_out_index == 32'd0))
        else $error("empty record not flagged last");
    a_code_slot_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot == cduleb_pkg::SLOT_CODE && r_phase != cduleb_pkg::PH_COUNTS)
        |-> is_method)
        else $error("code offset slot outside a method section");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !emit)
        else $error("pending record overwritten");
    a_idle_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && e_last) |=> (r_phase == cduleb_pkg::PH_IDLE || $past(first)))
        else $error("last record without return to idle");
`endif

endmodule

// ===== hdl/class_data_uleb_decoder_unit.sv =====
// Top level of the class data ULEB128 decoder.
// Joins front (byte assembly), value queue and back (record walk).
// Depends on cduleb_pkg, cduleb_front, cduleb_queue, cduleb_back.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_ready    i_data_byte, i_start_of_item
//   out      from block o_out_valid / i_out_ready  o_entry_kind, o_member_index,
//                                                  o_member_flags, o_code_offset,
//                                                  o_last_of_item
//
// One byte per cycle unless the output stalls; a record goes from its last byte
// through front assembly and the queue register into the back's output register.
// Synchronous active-low reset clears all control state; no clearing pass.
// The two-entry value queue stalls the front only when the back is held
// by a stalled output register.
`timescale 1ns / 1ps

module class_data_uleb_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_entry_kind,
    output logic [31:0] o_member_index,
    output logic [31:0] o_member_flags,
    output logic [31:0] o_code_offset,
    output logic        o_last_of_item
);

    logic             q_full, q_valid, push, pop;
    cduleb_pkg::t_val push_val, q_val;

    cduleb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_item (i_start_of_item),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_push_val      (push_val)
    );

    cduleb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_val (push_val),
        .o_full     (q_full),
        .o_q_valid  (q_valid),
        .o_q_val    (q_val),
        .i_pop      (pop)
    );

    cduleb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_val        (q_val),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entry_kind   (o_entry_kind),
        .o_member_index (o_member_index),
        .o_member_flags (o_member_flags),
        .o_code_offset  (o_code_offset),
        .o_last_of_item (o_last_of_item)
    );

endmodule
